### src/trht_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trht_pkg: shared types and constants of the touch region hit table
// Slot count, screen limits, mode and status codes, controller/datapath links.
// ----------------------------------------------------------------------------
package trht_pkg;

  localparam int unsigned SLOTS         = 16;
  localparam int unsigned SCREEN_WIDTH  = 1024;
  localparam int unsigned SCREEN_HEIGHT = 1024;

  localparam int unsigned COORD_W = 11;
  localparam int unsigned HAND_W  = 8;
  localparam int unsigned SLOT_W  = 4;
  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_REG   = 2'd1,
    MODE_DEREG = 2'd2,
    MODE_TOUCH = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_PARAM = 2'd1,
    STAT_NOT_REG   = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    FIN_CLEAR = 2'd0,
    FIN_BAD   = 2'd1,
    FIN_MATCH = 2'd2,
    FIN_MISS  = 2'd3
  } fin_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;     // latch the input item, restart the scan
    logic step;       // advance to the next slot
    logic commit;     // apply the slot action of the current mode
    logic clear_all;  // free every slot
    logic fin;        // capture the result
    fin_e fin_kind;
    logic load_out;   // move the result into the output register
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic is_clear;
    logic is_bad;
    logic match;
    logic last;
  } sts_t;

endpackage : trht_pkg
`default_nettype wire

### src/trht_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trht_ctrl: sequencing controller
// Accepts an item, walks the slots one per cycle, hands off the result.
// ----------------------------------------------------------------------------
module trht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  trht_pkg::sts_t sts_i,
  output trht_pkg::cmd_t cmd_o
);
  import trht_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q & out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.is_clear) begin
          cmd_o.clear_all = 1'b1;
          cmd_o.fin       = 1'b1;
          cmd_o.fin_kind  = FIN_CLEAR;
          state_d         = ST_DONE;
        end else if (sts_i.is_bad) begin
          cmd_o.fin      = 1'b1;
          cmd_o.fin_kind = FIN_BAD;
          state_d        = ST_DONE;
        end else if (sts_i.match) begin
          cmd_o.commit   = 1'b1;
          cmd_o.fin      = 1'b1;
          cmd_o.fin_kind = FIN_MATCH;
          state_d        = ST_DONE;
        end else if (sts_i.last) begin
          cmd_o.fin      = 1'b1;
          cmd_o.fin_kind = FIN_MISS;
          state_d        = ST_DONE;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      ST_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule : trht_ctrl
`default_nettype wire

### src/trht_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// trht_dp: slot table datapath
// Slot storage, item latch, per-slot compare, result and output registers.
// ----------------------------------------------------------------------------
module trht_dp (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  trht_pkg::cmd_t                 cmd_i,
  output trht_pkg::sts_t                 sts_o,
  input  logic [1:0]                     mode_i,
  input  logic [trht_pkg::COORD_W-1:0]   area_left_i,
  input  logic [trht_pkg::COORD_W-1:0]   area_top_i,
  input  logic [trht_pkg::COORD_W-1:0]   area_width_i,
  input  logic [trht_pkg::COORD_W-1:0]   area_height_i,
  input  logic [trht_pkg::HAND_W-1:0]    handler_id_i,
  input  logic [trht_pkg::COORD_W-1:0]   point_x_i,
  input  logic [trht_pkg::COORD_W-1:0]   point_y_i,
  output logic [1:0]                     status_o,
  output logic                           hit_o,
  output logic [trht_pkg::SLOT_W-1:0]    hit_slot_o,
  output logic [trht_pkg::HAND_W-1:0]    hit_handler_o
);
  import trht_pkg::*;

  // Latched item.
  mode_e              mode_q;
  logic [COORD_W-1:0] left_q, top_q, width_q, height_q, px_q, py_q;
  logic [HAND_W-1:0]  hid_q;
  logic [IDX_W-1:0]   idx_q;

  // Slot table: occupancy bits with reset, payload without.
  logic [SLOTS-1:0]   valid_q;
  logic [HAND_W-1:0]  slot_handler_q [SLOTS];
  logic [COORD_W-1:0] slot_left_q    [SLOTS];
  logic [COORD_W-1:0] slot_top_q     [SLOTS];
  logic [COORD_W-1:0] slot_width_q   [SLOTS];
  logic [COORD_W-1:0] slot_height_q  [SLOTS];

  // Result and output registers.
  status_e            res_status_q, out_status_q;
  logic               res_hit_q, out_hit_q;
  logic [SLOT_W-1:0]  res_slot_q, out_slot_q;
  logic [HAND_W-1:0]  res_hand_q, out_hand_q;

  logic               rect_bad;
  logic               cur_valid;
  logic [COORD_W-1:0] cur_left, cur_top, cur_width, cur_height;
  logic [COORD_W:0]   cur_right, cur_bottom;
  logic               eq_rect, pt_in;

  assign rect_bad =
      ((left_q == '0) && (top_q == '0) && (width_q == '0) && (height_q == '0)) ||
      (left_q  > COORD_W'(SCREEN_WIDTH))  || (top_q    > COORD_W'(SCREEN_HEIGHT)) ||
      (width_q > COORD_W'(SCREEN_WIDTH))  || (height_q > COORD_W'(SCREEN_HEIGHT));

  assign cur_valid  = valid_q[idx_q];
  assign cur_left   = slot_left_q[idx_q];
  assign cur_top    = slot_top_q[idx_q];
  assign cur_width  = slot_width_q[idx_q];
  assign cur_height = slot_height_q[idx_q];
  assign cur_right  = {1'b0, cur_left} + {1'b0, cur_width};
  assign cur_bottom = {1'b0, cur_top} + {1'b0, cur_height};

  assign eq_rect = (cur_left == left_q) && (cur_top == top_q) &&
                   (cur_width == width_q) && (cur_height == height_q);
  assign pt_in   = (px_q >= cur_left) && ({1'b0, px_q} <= cur_right) &&
                   (py_q >= cur_top) && ({1'b0, py_q} <= cur_bottom);

  always_comb begin
    sts_o          = '0;
    sts_o.is_clear = (mode_q == MODE_CLEAR);
    sts_o.last     = (idx_q == IDX_W'(SLOTS - 1));
    case (mode_q)
      MODE_REG: begin
        sts_o.is_bad = (hid_q == '0) || rect_bad;
        sts_o.match  = !cur_valid;
      end
      MODE_DEREG: begin
        sts_o.is_bad = rect_bad;
        sts_o.match  = cur_valid && eq_rect;
      end
      MODE_TOUCH: begin
        sts_o.match = cur_valid && pt_in;
      end
      default: begin
        sts_o.match = 1'b0;
      end
    endcase
  end

  // Item latch and scan index.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.accept) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mode_q   <= mode_e'(mode_i);
      left_q   <= area_left_i;
      top_q    <= area_top_i;
      width_q  <= area_width_i;
      height_q <= area_height_i;
      hid_q    <= handler_id_i;
      px_q     <= point_x_i;
      py_q     <= point_y_i;
    end
  end

  // Occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.clear_all) begin
      valid_q <= '0;
    end else if (cmd_i.commit) begin
      if (mode_q == MODE_REG) begin
        valid_q[idx_q] <= 1'b1;
      end else if (mode_q == MODE_DEREG) begin
        valid_q[idx_q] <= 1'b0;
      end
    end
  end

  // Slot payload, written on register only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && (mode_q == MODE_REG)) begin
      slot_handler_q[idx_q] <= hid_q;
      slot_left_q[idx_q]    <= left_q;
      slot_top_q[idx_q]     <= top_q;
      slot_width_q[idx_q]   <= width_q;
      slot_height_q[idx_q]  <= height_q;
    end
  end

  // Result capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      res_status_q <= STAT_OK;
      res_hit_q    <= 1'b0;
      res_slot_q   <= '0;
      res_hand_q   <= '0;
      case (cmd_i.fin_kind)
        FIN_BAD: begin
          res_status_q <= STAT_BAD_PARAM;
        end
        FIN_MATCH: begin
          if (mode_q == MODE_TOUCH) begin
            res_hit_q  <= 1'b1;
            res_slot_q <= SLOT_W'(idx_q);
            res_hand_q <= slot_handler_q[idx_q];
          end
        end
        FIN_MISS: begin
          if (mode_q == MODE_REG) begin
            res_status_q <= STAT_FULL;
          end else if (mode_q == MODE_DEREG) begin
            res_status_q <= STAT_NOT_REG;
          end
        end
        default: begin
          res_status_q <= STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_status_q <= res_status_q;
      out_hit_q    <= res_hit_q;
      out_slot_q   <= res_slot_q;
      out_hand_q   <= res_hand_q;
    end
  end

  assign status_o      = out_status_q;
  assign hit_o         = out_hit_q;
  assign hit_slot_o    = out_slot_q;
  assign hit_handler_o = out_hand_q;

endmodule : trht_dp
`default_nettype wire

### src/touch_region_hit_table_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// touch_region_hit_table_core: touch region hit table
// Table of screen rectangles with handler ids: clear, register, deregister
// and point hit test, one slot examined per cycle.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+-------------------------------------------
//  in      | in_valid_i / in_stall_o   | mode, area rectangle, handler, point
//  out     | out_valid_o / out_stall_i | status, hit, hit_slot, hit_handler
//
// A clear, or a register or deregister with bad parameters, ends the item
// without a slot scan; otherwise the scan visits one slot a cycle, up to
// SLOTS slots, and stops at the first free, equal or containing slot.
// Reset frees every slot at once through the occupancy bits.
// in_stall_o is high from acceptance until the result enters the output
// register; a stalled result is held there while the next item is taken.
//
module touch_region_hit_table_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   mode_i,
  input  logic [trht_pkg::COORD_W-1:0] area_left_i,
  input  logic [trht_pkg::COORD_W-1:0] area_top_i,
  input  logic [trht_pkg::COORD_W-1:0] area_width_i,
  input  logic [trht_pkg::COORD_W-1:0] area_height_i,
  input  logic [trht_pkg::HAND_W-1:0]  handler_id_i,
  input  logic [trht_pkg::COORD_W-1:0] point_x_i,
  input  logic [trht_pkg::COORD_W-1:0] point_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [1:0]                   status_o,
  output logic                         hit_o,
  output logic [trht_pkg::SLOT_W-1:0]  hit_slot_o,
  output logic [trht_pkg::HAND_W-1:0]  hit_handler_o
);
  import trht_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing: accept, scan, hand off.
  trht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Slot table, compare logic and result registers.
  trht_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .mode_i        (mode_i),
    .area_left_i   (area_left_i),
    .area_top_i    (area_top_i),
    .area_width_i  (area_width_i),
    .area_height_i (area_height_i),
    .handler_id_i  (handler_id_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .status_o      (status_o),
    .hit_o         (hit_o),
    .hit_slot_o    (hit_slot_o),
    .hit_handler_o (hit_handler_o)
  );

endmodule : touch_region_hit_table_core
`default_nettype wire
